@@ rtl/tra_pkg.sv @@
`default_nettype none
package tra_pkg;

	localparam int MAX_REGIONS = 16;
	localparam int SIZE_BITS   = 20;
	localparam int ADDR_W      = 64;
	localparam int CNT_W       = $clog2(MAX_REGIONS + 1);
	localparam int TOTAL_W     = 32;

	typedef enum logic [2:0] {
		ST_REGISTERED = 3'd0,
		ST_FULL       = 3'd1,
		ST_MISS       = 3'd2,
		ST_ENTRY      = 3'd3,
		ST_MIDDLE     = 3'd4
	} status_t;

	// An item as it travels down the row of region cells.
	typedef struct packed {
		logic                 audit;
		logic [ADDR_W-1:0]    address;
		logic [CNT_W-1:0]     count;
		logic                 found;
		logic [SIZE_BITS-1:0] offset;
		logic [ADDR_W-1:0]    copy;
		status_t              status;
	} item_t;

	function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
		sat_inc = (&v) ? v : v + TOTAL_W'(1);
	endfunction

endpackage
`default_nettype wire

@@ rtl/tra_cell.sv @@
`default_nettype none
module tra_cell
	import tra_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 adv,
	input  wire logic [CNT_W-1:0]     cell_idx,
	input  wire logic                 we,
	input  wire logic [ADDR_W-1:0]    wr_trap,
	input  wire logic [ADDR_W-1:0]    wr_copy,
	input  wire logic [SIZE_BITS-1:0] wr_len,
	input  wire logic                 in_valid,
	input  wire item_t                in_item,
	output logic                      out_valid,
	output item_t                     out_item
);

	logic [ADDR_W-1:0]    trap_q;
	logic [ADDR_W-1:0]    copy_q;
	logic [SIZE_BITS-1:0] len_q;
	logic                 valid_q;
	item_t                item_q;
	logic [ADDR_W:0]      diff;
	logic                 hit;
	item_t                nxt;

	always_ff @(posedge clk) begin
		if (we) begin
			trap_q <= wr_trap;
			copy_q <= wr_copy;
			len_q  <= wr_len;
		end
	end

	// The 65-bit difference gives the borrow for address below start, and the
	// offset must fit under the length, so the range end never wraps.
	always_comb begin
		diff = {1'b0, in_item.address} - {1'b0, trap_q};
		hit  = in_item.audit && !in_item.found && (cell_idx < in_item.count) &&
		       !diff[ADDR_W] && (diff[ADDR_W-1:SIZE_BITS] == '0) &&
		       (diff[SIZE_BITS-1:0] < len_q);
		nxt  = in_item;
		if (hit) begin
			nxt.found  = 1'b1;
			nxt.offset = diff[SIZE_BITS-1:0];
			nxt.copy   = copy_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule
`default_nettype wire

@@ rtl/tra_tail.sv @@
`default_nettype none
module tra_tail
	import tra_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                adv,
	input  wire logic                in_valid,
	input  wire item_t               in_item,
	output logic                     res_valid,
	output status_t                  res_status,
	output logic [ADDR_W-1:0]        res_redirect,
	output logic                     res_rerand,
	output logic [TOTAL_W-1:0]       res_benign,
	output logic [TOTAL_W-1:0]       res_gadget,
	output logic [TOTAL_W-1:0]       res_trigger
);

	logic                 valid_q;
	status_t              status_q;
	logic [ADDR_W-1:0]    redirect_q;
	logic                 rerand_q;
	logic [TOTAL_W-1:0]   benign_q;
	logic [TOTAL_W-1:0]   gadget_q;
	logic [TOTAL_W-1:0]   trigger_q;
	logic                 entry_hit;
	logic                 middle_hit;

	assign entry_hit  = in_item.audit && in_item.found && (in_item.offset == '0);
	assign middle_hit = in_item.audit && in_item.found && (in_item.offset != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			benign_q  <= '0;
			gadget_q  <= '0;
			trigger_q <= '0;
		end else if (adv) begin
			valid_q <= in_valid;
			if (in_valid && entry_hit) begin
				benign_q <= sat_inc(benign_q);
			end
			if (in_valid && middle_hit) begin
				gadget_q  <= sat_inc(gadget_q);
				trigger_q <= sat_inc(trigger_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rerand_q <= middle_hit;
			if (in_item.audit && in_item.found) begin
				redirect_q <= in_item.copy + ADDR_W'(in_item.offset);
				status_q   <= entry_hit ? ST_ENTRY : ST_MIDDLE;
			end else begin
				redirect_q <= '0;
				status_q   <= in_item.status;
			end
		end
	end

	assign res_valid    = valid_q;
	assign res_status   = status_q;
	assign res_redirect = redirect_q;
	assign res_rerand   = rerand_q;
	assign res_benign   = benign_q;
	assign res_gadget   = gadget_q;
	assign res_trigger  = trigger_q;

endmodule
`default_nettype wire

@@ rtl/trap_region_redirect_auditor.sv @@
`default_nettype none
// Trap region redirect auditor.
// Input items arrive on the s_ channel. s_tuser selects the kind: 0 registers
// a region (trap start, copy start, size), 1 audits a faulting address.
// Results leave on the m_ channel, one per input item, in order. m_tuser holds
// the status code and m_tdata the redirect address, the rerandomize flag and
// the three saturating totals.
// Each region lives in its own cell of a row of MAX_REGIONS cells. Every item
// walks the row one cell per cycle unless the receiver stalls, and the first
// cell whose range holds the address claims it. The row is a pipeline, so one
// item can be accepted every cycle unless the receiver stalls.
// Each item carries the region count seen at acceptance, so later
// registrations never affect an earlier audit.
// Reset clears the region count and the totals; the table is empty.
// When the receiver stalls, the whole row holds and s_tready drops until the
// waiting result is taken.
module trap_region_redirect_auditor
	import tra_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// address [63:0], copy_base [127:64], region_size [147:128], zero fill
	input  wire logic [151:0] s_tdata,
	// kind [0]
	input  wire logic [0:0]   s_tuser,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// redirect_address [63:0], rerandomize_request [64], benign_total [96:65],
	// gadget_total [128:97], trigger_total [160:129], zero fill
	output logic [167:0]      m_tdata,
	// status [2:0]
	output logic [2:0]        m_tuser
);

	logic                 adv;
	logic                 accept;
	logic                 reg_item;
	logic                 full;
	logic [CNT_W-1:0]     count_q;
	logic [ADDR_W-1:0]    in_address;
	logic [ADDR_W-1:0]    in_copy;
	logic [SIZE_BITS-1:0] in_size;
	logic                 chain_valid [0:MAX_REGIONS];
	item_t                chain_item  [0:MAX_REGIONS];
	status_t              res_status;
	logic [ADDR_W-1:0]    res_redirect;
	logic                 res_rerand;
	logic [TOTAL_W-1:0]   res_benign;
	logic [TOTAL_W-1:0]   res_gadget;
	logic [TOTAL_W-1:0]   res_trigger;

	assign adv        = !m_tvalid || m_tready;
	assign s_tready   = adv;
	assign accept     = s_tvalid && adv;
	assign in_address = s_tdata[63:0];
	assign in_copy    = s_tdata[127:64];
	assign in_size    = s_tdata[128 +: SIZE_BITS];
	assign reg_item   = !s_tuser[0];
	assign full       = (count_q == CNT_W'(MAX_REGIONS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept && reg_item && !full) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	always_comb begin
		chain_valid[0]        = s_tvalid;
		chain_item[0].audit   = s_tuser[0];
		chain_item[0].address = in_address;
		chain_item[0].count   = count_q;
		chain_item[0].found   = 1'b0;
		chain_item[0].offset  = '0;
		chain_item[0].copy    = '0;
		if (!reg_item) begin
			chain_item[0].status = ST_MISS;
		end else if (full) begin
			chain_item[0].status = ST_FULL;
		end else begin
			chain_item[0].status = ST_REGISTERED;
		end
	end

	for (genvar i = 0; i < MAX_REGIONS; i++) begin : g_cell
		tra_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.adv       (adv),
			.cell_idx  (CNT_W'(i)),
			.we        (accept && reg_item && (count_q == CNT_W'(i))),
			.wr_trap   (in_address),
			.wr_copy   (in_copy),
			.wr_len    (in_size),
			.in_valid  (chain_valid[i]),
			.in_item   (chain_item[i]),
			.out_valid (chain_valid[i+1]),
			.out_item  (chain_item[i+1])
		);
	end

	tra_tail u_tail (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.in_valid     (chain_valid[MAX_REGIONS]),
		.in_item      (chain_item[MAX_REGIONS]),
		.res_valid    (m_tvalid),
		.res_status   (res_status),
		.res_redirect (res_redirect),
		.res_rerand   (res_rerand),
		.res_benign   (res_benign),
		.res_gadget   (res_gadget),
		.res_trigger  (res_trigger)
	);

	assign m_tuser = res_status;
	assign m_tdata = {7'd0, res_trigger, res_gadget, res_benign, res_rerand, res_redirect};

endmodule
`default_nettype wire

@@ bench/tb_trap_region_redirect_auditor.sv @@
`default_nettype none
module tb_trap_region_redirect_auditor;
	import tra_pkg::*;

	localparam logic KIND_REGISTER = 1'b0;
	localparam logic KIND_AUDIT    = 1'b1;
	localparam int   QUIET_LIMIT   = 4000;
	localparam int   HOLD_CYCLES   = 400;
	localparam int   PHASE_ITEMS   = 240;
	localparam int   TAIL_CYCLES   = 2 * MAX_REGIONS + 8;

	typedef struct {
		logic                 kind;
		logic [ADDR_W-1:0]    address;
		logic [ADDR_W-1:0]    copy;
		logic [SIZE_BITS-1:0] size;
	} probe_t;

	typedef struct {
		status_t            status;
		logic [ADDR_W-1:0]  redirect;
		logic               rerand;
		logic [TOTAL_W-1:0] benign;
		logic [TOTAL_W-1:0] gadget;
		logic [TOTAL_W-1:0] trigger;
	} verdict_t;

	typedef enum {PACE_FREE, PACE_SEND_SLOW, PACE_RECV_SLOW, PACE_BOTH_SLOW,
		PACE_BACKPRESSURE} pace_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [151:0] s_tdata = '0;
	logic [0:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [167:0] m_tdata;
	logic [2:0]   m_tuser;

	trap_region_redirect_auditor uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Region table as the block should hold it, updated at item acceptance.
	logic [ADDR_W-1:0]    tbl_trap [MAX_REGIONS];
	logic [ADDR_W-1:0]    tbl_copy [MAX_REGIONS];
	logic [SIZE_BITS-1:0] tbl_len [MAX_REGIONS];
	int                   tbl_used = 0;
	logic [TOTAL_W-1:0]   benign_seen = '0;
	logic [TOTAL_W-1:0]   gadget_seen = '0;
	logic [TOTAL_W-1:0]   trigger_seen = '0;

	// Regions as the stimulus plans them, so audits can aim at real ranges.
	logic [ADDR_W-1:0]    plan_start [$];
	logic [SIZE_BITS-1:0] plan_len [$];

	probe_t   items_waiting [$];
	verdict_t verdicts_due [$];
	probe_t   on_bus;
	pace_t    pace = PACE_FREE;
	int       send_idle_pct = 0;
	int       recv_stall_pct = 0;
	int       hold_left = 0;
	bit       hold_done = 1'b0;
	int       quiet = 0;
	int       errors = 0;

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic [TOTAL_W-1:0] bump_total(input logic [TOTAL_W-1:0] v);
		return (v == '1) ? v : v + 1'b1;
	endfunction

	function automatic verdict_t resolve_item(input probe_t p);
		verdict_t          v;
		logic [ADDR_W:0]   stop;
		logic [ADDR_W-1:0] off;
		bit                claimed;
		v.status = ST_MISS;
		v.redirect = '0;
		v.rerand = 1'b0;
		claimed = 1'b0;
		if (p.kind == KIND_REGISTER) begin
			if (tbl_used >= MAX_REGIONS) begin
				v.status = ST_FULL;
			end else begin
				tbl_trap[tbl_used] = p.address;
				tbl_copy[tbl_used] = p.copy;
				tbl_len[tbl_used] = p.size;
				tbl_used++;
				v.status = ST_REGISTERED;
			end
		end else begin
			for (int i = 0; i < MAX_REGIONS; i++) begin
				if (!claimed && i < tbl_used) begin
					// The end is kept one bit wider so high regions never wrap.
					stop = {1'b0, tbl_trap[i]} + tbl_len[i];
					if (p.address >= tbl_trap[i] && {1'b0, p.address} < stop) begin
						claimed = 1'b1;
						off = p.address - tbl_trap[i];
						v.redirect = tbl_copy[i] + off;
						if (off == '0) begin
							v.status = ST_ENTRY;
							benign_seen = bump_total(benign_seen);
						end else begin
							v.status = ST_MIDDLE;
							v.rerand = 1'b1;
							gadget_seen = bump_total(gadget_seen);
							trigger_seen = bump_total(trigger_seen);
						end
					end
				end
			end
		end
		v.benign = benign_seen;
		v.gadget = gadget_seen;
		v.trigger = trigger_seen;
		return v;
	endfunction

	function automatic void queue_item(input logic kind, input logic [ADDR_W-1:0] address,
			input logic [ADDR_W-1:0] copy, input logic [SIZE_BITS-1:0] size);
		probe_t p;
		p.kind = kind;
		p.address = address;
		p.copy = copy;
		p.size = size;
		items_waiting.push_back(p);
		if (kind == KIND_REGISTER && plan_start.size() < MAX_REGIONS) begin
			plan_start.push_back(address);
			plan_len.push_back(size);
		end
	endfunction

	function automatic logic [ADDR_W-1:0] any_word();
		return {$urandom, $urandom};
	endfunction

	function automatic void queue_random(input int count);
		logic [ADDR_W-1:0]    base;
		logic [SIZE_BITS-1:0] len;
		logic [ADDR_W-1:0]    off;
		int                   r;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(9) == 0) begin
				case ($urandom_range(7))
					0: len = '0;
					1: len = '1;
					2, 3: len = SIZE_BITS'($urandom);
					default: len = SIZE_BITS'($urandom_range(64, 1));
				endcase
				queue_item(KIND_REGISTER, any_word(), any_word(), len);
			end else if (plan_start.size() == 0 || $urandom_range(7) == 0) begin
				queue_item(KIND_AUDIT, any_word(), any_word(), SIZE_BITS'($urandom));
			end else begin
				r = $urandom_range(plan_start.size() - 1);
				base = plan_start[r];
				len = plan_len[r];
				case ($urandom_range(5))
					0: off = '0;
					1: off = ADDR_W'(len) - 1;
					2: off = ADDR_W'(len);
					3: off = '1;
					default: off = (len == '0) ? '0 : ADDR_W'($urandom_range(len - 1));
				endcase
				queue_item(KIND_AUDIT, base + off, any_word(), SIZE_BITS'($urandom));
			end
		end
	endfunction

	task automatic compare_field(input string field, input logic [ADDR_W-1:0] want,
			input logic [ADDR_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : drive_items
		probe_t nxt;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				verdicts_due.push_back(resolve_item(on_bus));
			end
			if (!s_tvalid || s_tready) begin
				if (items_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = items_waiting.pop_front();
					on_bus <= nxt;
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0, nxt.size, nxt.copy, nxt.address};
					s_tuser <= nxt.kind;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : check_results
		verdict_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (verdicts_due.size() == 0) begin
					$display("%0t: result with nothing expected, status %0d, data %h",
						$time, m_tuser, m_tdata);
					errors++;
				end else begin
					want = verdicts_due.pop_front();
					compare_field("status", ADDR_W'(want.status), ADDR_W'(m_tuser));
					compare_field("redirect_address", want.redirect, m_tdata[63:0]);
					compare_field("rerandomize_request", ADDR_W'(want.rerand),
						ADDR_W'(m_tdata[64]));
					compare_field("benign_total", ADDR_W'(want.benign), ADDR_W'(m_tdata[96:65]));
					compare_field("gadget_total", ADDR_W'(want.gadget), ADDR_W'(m_tdata[128:97]));
					compare_field("trigger_total", ADDR_W'(want.trigger),
						ADDR_W'(m_tdata[160:129]));
				end
			end
			// One long hold-off lets the row fill up and push back on the sender.
			if (pace == PACE_BACKPRESSURE && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= HOLD_CYCLES;
				m_tready <= 1'b0;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				quiet <= 0;
			end else begin
				quiet <= quiet + 1;
				if (quiet == QUIET_LIMIT) begin
					$display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
					$display("Simulation FAILED");
					$finish;
				end
			end
		end
	end

	task automatic drain();
		while (items_waiting.size() != 0 || verdicts_due.size() != 0 || s_tvalid)
			@(negedge clk);
	endtask

	task automatic run_phase(input pace_t p, input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		queue_random(PHASE_ITEMS);
		pace = p;
		drain();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty table, then regions at both ends of the address space.
		queue_item(KIND_AUDIT, '0, '0, '0);
		queue_item(KIND_AUDIT, '1, '1, '1);
		queue_item(KIND_REGISTER, '0, '1, '1);
		queue_item(KIND_REGISTER, 64'hFFFF_FFFF_FFFF_FF00, 64'h1000, '1);
		queue_item(KIND_REGISTER, 64'h8000_0000_0000_0000, 64'hA5A5_A5A5_A5A5_A5A5, '0);
		// This one lies inside the first region, which must win.
		queue_item(KIND_REGISTER, 64'h10, 64'h5555_5555_5555_5555, 20'h10);
		queue_item(KIND_AUDIT, '0, '0, '0);
		queue_item(KIND_AUDIT, 64'h1, '0, '0);
		queue_item(KIND_AUDIT, 64'h10, '0, '0);
		queue_item(KIND_AUDIT, 64'hF_FFFE, '0, '0);
		queue_item(KIND_AUDIT, 64'hF_FFFF, '0, '0);
		queue_item(KIND_AUDIT, 64'hFFFF_FFFF_FFFF_FF00, '0, '0);
		queue_item(KIND_AUDIT, '1, '0, '0);
		queue_item(KIND_AUDIT, 64'h8000_0000_0000_0000, '0, '0);
		queue_item(KIND_REGISTER, 64'h4000_0000, '0, 20'h1);
		queue_item(KIND_AUDIT, 64'h4000_0000, '1, '1);
		queue_item(KIND_AUDIT, 64'h4000_0001, '1, '1);
		queue_item(KIND_AUDIT, 64'h3FFF_FFFF, '1, '1);
		drain();

		run_phase(PACE_FREE, 0, 0);
		run_phase(PACE_SEND_SLOW, 80, 0);
		run_phase(PACE_RECV_SLOW, 0, 80);
		run_phase(PACE_BOTH_SLOW, 11, 11);
		run_phase(PACE_BACKPRESSURE, 0, 0);

		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors == 0 && verdicts_due.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
